// ===== rtl/bpl_pkg.sv =====
// Shared constants and controller/datapath interface types of the block peak limiter.
package bpl_pkg;

  // Storage depth and derived widths
  localparam int MAX_BLOCK = 2048;
  localparam int IDX_W     = $clog2(MAX_BLOCK);
  localparam int FILL_W    = IDX_W + 1;

  // Field widths
  localparam int SAMPLE_W = 20;
  localparam int OUT_W    = 16;
  localparam int BLK_W    = 12;
  localparam int CEIL_W   = 15;
  localparam int GAIN_W   = 17;
  localparam int Q_W      = 16;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = SAMPLE_W + GAIN_W;
  localparam int P_W      = PROD_W - FRAC_W;

  // Serial divider: one quotient bit per step
  localparam int DIV_STEPS = Q_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Release step: gap * 33 / 65536, built as gap * 32 + gap
  localparam int REL_SHIFT = 5;
  localparam int REL_W     = GAIN_W + REL_SHIFT + 1;

  // Configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = CEIL_W;

  localparam logic [CFG_AW-1:0] CFG_BLOCK_SAMPLES  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_LIMITER_ENABLE = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_MUTE           = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_CEILING        = 2'd3;

  localparam logic [BLK_W-1:0]  BLK_SAMPLES_RST = 12'd1764;
  localparam logic [BLK_W-1:0]  BLK_MIN         = 12'd2;
  localparam logic [CEIL_W-1:0] CEILING_RST     = 15'd32000;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'd65536;

  localparam logic [OUT_W-1:0] OUT_POS_MAX = 16'h7fff;
  localparam logic [OUT_W-1:0] OUT_NEG_MAX = 16'h8000;

  typedef struct packed {
    logic accept;
    logic gain_en;
    logic mul_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_busy;
  } sts_t;

endpackage

// ===== rtl/bpl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bpl_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // Read returns the old contents when both ports hit the same entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bpl_div.sv =====
// Restoring serial divider producing the block target gain, one quotient bit a cycle.
module bpl_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bpl_pkg::CEIL_W-1:0]  num,
  input  logic [bpl_pkg::SAMPLE_W-1:0] den,
  output logic                        busy,
  output logic                        done,
  output logic [bpl_pkg::Q_W-1:0]     quot
);
  import bpl_pkg::*;

  logic [SAMPLE_W-1:0]  rem_r, rem_nxt;
  logic [SAMPLE_W-1:0]  den_r;
  logic [Q_W-1:0]       q_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [SAMPLE_W:0]    shifted;
  logic [SAMPLE_W:0]    diff;
  logic                 ge;

  // Numerator is num * 2^16; the remainder starts below the divisor when num < den
  always_comb begin
    shifted = {rem_r, 1'b0};
    diff    = shifted - {1'b0, den_r};
    ge      = shifted >= {1'b0, den_r};
    rem_nxt = ge ? diff[SAMPLE_W-1:0] : shifted[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == DIV_CNT_W'(1));
      if (start) begin
        cnt_r <= DIV_CNT_W'(DIV_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= SAMPLE_W'(num);
      den_r <= den;
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[Q_W-2:0], ge};
    end
  end

  assign busy = (cnt_r != '0) || done_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== rtl/bpl_dpath.sv =====
// Limiter datapath: config registers, delay store, peak tracking, gain smoothing, scaling.
module bpl_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bpl_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [bpl_pkg::CFG_DW-1:0]    cfg_data,
  input  logic signed [bpl_pkg::SAMPLE_W-1:0] in_summed_sample,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic signed [bpl_pkg::OUT_W-1:0] out_limited_sample,
  output logic                          out_clipped,
  output logic                          out_block_last,
  input  bpl_pkg::cmd_t                 cmd,
  output bpl_pkg::sts_t                 sts
);
  import bpl_pkg::*;

  function automatic logic [SAMPLE_W-1:0] mag(input logic [SAMPLE_W-1:0] v);
    logic [SAMPLE_W-1:0] neg;
    neg = (~v) + 1'b1;
    return v[SAMPLE_W-1] ? neg : v;
  endfunction

  // Configuration registers
  logic [BLK_W-1:0]  blk_samples_r;
  logic              lim_en_r;
  logic              mute_r;
  logic [CEIL_W-1:0] ceiling_r;

  // Block state
  logic [IDX_W-1:0]    idx_r;
  logic [FILL_W-1:0]   fill_r;
  logic [SAMPLE_W-1:0] peak_r;
  logic [GAIN_W-1:0]   target_r;
  logic [GAIN_W-1:0]   gain_r;
  logic                limit_r;

  // Per-item pipeline
  logic                old_valid_r;
  logic                last_r;
  logic [SAMPLE_W-1:0] om_r;
  logic                neg_r;
  logic [PROD_W-1:0]   prod_r;

  // Output register
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_sample_r;
  logic                out_clip_r;
  logic                out_last_r;

  logic [BLK_W-1:0]    blk_len;
  logic [FILL_W-1:0]   idx_p1;
  logic                last;
  logic [SAMPLE_W-1:0] mag_in;
  logic [SAMPLE_W-1:0] peak_new;
  logic [SAMPLE_W-1:0] rdata;
  logic [GAIN_W-1:0]   gap;
  logic [REL_W-1:0]    rel;
  logic [GAIN_W-1:0]   gain_step;
  logic [P_W-1:0]      p;
  logic [P_W-1:0]      p_neg;
  logic [OUT_W-1:0]    res;
  logic                clip;
  logic                div_start;
  logic                div_busy;
  logic                div_done;
  logic [Q_W-1:0]      quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_samples_r <= BLK_SAMPLES_RST;
      lim_en_r      <= 1'b1;
      mute_r        <= 1'b0;
      ceiling_r     <= CEILING_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_SAMPLES:  blk_samples_r <= cfg_data[BLK_W-1:0];
        CFG_LIMITER_ENABLE: lim_en_r      <= cfg_data[0];
        CFG_MUTE:           mute_r        <= cfg_data[0];
        CFG_CEILING:        ceiling_r     <= cfg_data[CEIL_W-1:0];
        default: ;
      endcase
    end
  end

  // Block length clamped to the supported range
  always_comb begin
    if (blk_samples_r < BLK_MIN) begin
      blk_len = BLK_MIN;
    end else if (blk_samples_r > BLK_W'(MAX_BLOCK)) begin
      blk_len = BLK_W'(MAX_BLOCK);
    end else begin
      blk_len = blk_samples_r;
    end
  end

  always_comb begin
    idx_p1    = {1'b0, idx_r} + 1'b1;
    last      = idx_p1 >= FILL_W'(blk_len);
    mag_in    = mag(in_summed_sample);
    peak_new  = (mag_in > peak_r) ? mag_in : peak_r;
    div_start = cmd.accept && last;
  end

  // Entries at or above the fill mark were never written and read as zero
  bpl_ram #(
    .W     (SAMPLE_W),
    .DEPTH (MAX_BLOCK)
  ) u_store (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (idx_r),
    .wdata (in_summed_sample),
    .raddr (idx_r),
    .rdata (rdata)
  );

  bpl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (ceiling_r),
    .den   (peak_new),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      fill_r   <= '0;
      peak_r   <= '0;
      target_r <= UNITY_GAIN;
      gain_r   <= UNITY_GAIN;
    end else begin
      if (cmd.accept) begin
        if ({1'b0, idx_r} == fill_r) begin
          fill_r <= idx_p1;
        end
        if (last) begin
          idx_r  <= '0;
          peak_r <= '0;
        end else begin
          idx_r  <= idx_p1[IDX_W-1:0];
          peak_r <= peak_new;
        end
      end
      // Hold the gain while muted
      if (cmd.gain_en && !mute_r) begin
        gain_r <= gain_step;
      end
      if (div_done) begin
        target_r <= limit_r ? GAIN_W'(quot) : UNITY_GAIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      old_valid_r <= {1'b0, idx_r} < fill_r;
      last_r      <= last;
    end
    if (div_start) begin
      limit_r <= lim_en_r && (peak_new > SAMPLE_W'(ceiling_r));
    end
    if (cmd.gain_en) begin
      om_r  <= old_valid_r ? mag(rdata) : '0;
      neg_r <= old_valid_r && rdata[SAMPLE_W-1];
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(om_r) * PROD_W'(gain_r);
    end
  end

  // Attack closes a quarter of the gap; release closes 33/65536 of it
  always_comb begin
    rel = '0;
    if (target_r < gain_r) begin
      gap       = gain_r - target_r;
      gain_step = gain_r - (gap >> 2);
    end else begin
      gap       = target_r - gain_r;
      rel       = {1'b0, gap, {REL_SHIFT{1'b0}}} + REL_W'(gap);
      gain_step = gain_r + GAIN_W'(rel >> FRAC_W);
    end
  end

  // Truncate toward zero on the magnitude, then saturate to 16 bits
  always_comb begin
    p     = prod_r[PROD_W-1:FRAC_W];
    p_neg = P_W'(0) - p;
    res   = '0;
    clip  = 1'b0;
    if (!mute_r) begin
      if (neg_r) begin
        if (p > P_W'(OUT_NEG_MAX)) begin
          res  = OUT_NEG_MAX;
          clip = 1'b1;
        end else begin
          res = p_neg[OUT_W-1:0];
        end
      end else begin
        if (p > P_W'(OUT_POS_MAX)) begin
          res  = OUT_POS_MAX;
          clip = 1'b1;
        end else begin
          res = p[OUT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample_r <= res;
      out_clip_r   <= clip;
      out_last_r   <= last_r;
    end
  end

  assign sts.out_free        = !out_valid_r || !out_stall;
  assign sts.div_busy        = div_busy;
  assign out_valid           = out_valid_r;
  assign out_limited_sample  = $signed(out_sample_r);
  assign out_clipped         = out_clip_r;
  assign out_block_last      = out_last_r;

endmodule

// ===== rtl/bpl_ctrl.sv =====
// Limiter controller: sequences one sample through read, gain step, multiply and hand-off.
module bpl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output bpl_pkg::cmd_t cmd,
  input  bpl_pkg::sts_t sts
);
  import bpl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAIN,
    S_MUL,
    S_SAT,
    S_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   stall_r;
  logic   accept;

  assign accept = in_valid && !stall_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_GAIN;
      S_GAIN:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_SAT;
      S_SAT:   if (sts.out_free) state_nxt = S_DRAIN;
      // Wait for the next target gain before taking another sample
      S_DRAIN: if (!sts.div_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stall_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stall_r <= (state_nxt != S_IDLE);
    end
  end

  always_comb begin
    cmd.accept   = accept;
    cmd.gain_en  = (state_r == S_GAIN);
    cmd.mul_en   = (state_r == S_MUL);
    cmd.out_load = (state_r == S_SAT) && sts.out_free;
  end

  assign in_stall = stall_r;

endmodule

// ===== rtl/block_peak_limiter_unit.sv =====
// Block peak limiter top level: controller plus datapath.
//
// Each input sample is stored in a one-block delay memory and the sample one block older at the
// same position is emitted, scaled by a smoothed gain that chases a per-block target. After each
// transfer the input stays stalled while the sample passes through memory read at the transfer,
// then gain step, 20x17 multiply, saturation with the load of the output register, and a drain
// state that releases the stall, so a new sample is taken only once the last is through. The last
// sample of a block also starts the serial divider that forms the next target gain (ceiling *
// 65536 / peak, or unity when the peak is within the ceiling or limiting is off), and the input
// stays stalled until it finishes. A result stalled downstream holds the next one in saturation
// until the output register frees; the output register lets a new sample transfer while a result
// still waits downstream. After reset the delay memory reads as zero through a fill mark, so
// there is no clearing pass. Configuration writes must be made while no sample is in flight.
module block_peak_limiter_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [bpl_pkg::SAMPLE_W-1:0] in_summed_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [bpl_pkg::OUT_W-1:0]   out_limited_sample,
  output logic                               out_clipped,
  output logic                               out_block_last,
  input  logic                               cfg_we,
  input  logic [bpl_pkg::CFG_AW-1:0]         cfg_index,
  input  logic [bpl_pkg::CFG_DW-1:0]         cfg_data
);
  import bpl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bpl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  bpl_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_summed_sample   (in_summed_sample),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_limited_sample (out_limited_sample),
    .out_clipped        (out_clipped),
    .out_block_last     (out_block_last),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

// ===== rtl/bpl_checker.sv =====
// Port-level checks for the block peak limiter, bound to the top level.
module bpl_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [bpl_pkg::OUT_W-1:0]   out_limited_sample,
  input logic                               out_clipped,
  input logic                               out_block_last
);
  import bpl_pkg::*;

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // One sample in flight: a transfer stalls the input on the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transfer");

  // A clipped result sits at one of the two rails
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      (out_limited_sample == $signed(OUT_POS_MAX)) ||
      (out_limited_sample == $signed(OUT_NEG_MAX)))
    else $error("clipped flag on an unsaturated sample");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_limited_sample) &&
      $stable(out_clipped) && $stable(out_block_last))
    else $error("stalled result changed");

endmodule

bind block_peak_limiter_unit bpl_checker u_bpl_checker (.*);
